[rtl/eatrm_pkg.sv]
// ----------------------------------------------------------------------------
// eatrm_pkg
// Shared constants and types for the Euler angle to rotation matrix datapath.
// ----------------------------------------------------------------------------
package eatrm_pkg;

  localparam int unsigned STEPS = 30;   // CORDIC iterations
  localparam int unsigned XW    = 33;   // CORDIC x/y/z width, signed
  localparam int unsigned TW    = 32;   // sine/cosine width, signed Q30

  localparam logic signed [XW-1:0] CORDIC_GAIN = 33'sd652032874;
  localparam logic signed [TW-1:0] TRIG_ONE    = 32'sd1073741824;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [31:0] ARC_TABLE [STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
    32'd20,        32'd10,        32'd5,         32'd3,        32'd1
  };

  typedef struct packed {
    logic signed [TW-1:0] sin;
    logic signed [TW-1:0] cos;
  } trig_t;

endpackage

[rtl/eatrm_cordic.sv]
// ----------------------------------------------------------------------------
// eatrm_cordic
// Pipelined rotation-mode CORDIC: 32-bit turn in, sine and cosine (Q30) out.
// One register stage for setup, one per iteration, one for quadrant fix-up.
// ----------------------------------------------------------------------------
module eatrm_cordic
  import eatrm_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] turn,
  output trig_t       trig
);

  logic signed [XW-1:0] x_r [STEPS+1];
  logic signed [XW-1:0] y_r [STEPS+1];
  logic signed [XW-1:0] z_r [STEPS+1];
  logic [1:0]           q_r [STEPS+1];
  trig_t                trig_r;

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= CORDIC_GAIN;
      y_r[0] <= '0;
      z_r[0] <= {3'b000, turn[29:0]};
      q_r[0] <= turn[31:30];
    end
  end

  for (genvar g = 0; g < STEPS; g++) begin : g_step
    localparam logic signed [XW-1:0] ARC = XW'(ARC_TABLE[g]);
    always_ff @(posedge clk) begin
      if (en) begin
        q_r[g+1] <= q_r[g];
        if (!z_r[g][XW-1]) begin
          x_r[g+1] <= x_r[g] - (y_r[g] >>> g);
          y_r[g+1] <= y_r[g] + (x_r[g] >>> g);
          z_r[g+1] <= z_r[g] - ARC;
        end else begin
          x_r[g+1] <= x_r[g] + (y_r[g] >>> g);
          y_r[g+1] <= y_r[g] - (x_r[g] >>> g);
          z_r[g+1] <= z_r[g] + ARC;
        end
      end
    end
  end

  logic signed [XW-1:0] one_x;
  logic signed [TW-1:0] c_cl, s_cl;
  trig_t                trig_nxt;

  assign one_x = XW'(TRIG_ONE);

  always_comb begin
    if (x_r[STEPS] > one_x)       c_cl = TRIG_ONE;
    else if (x_r[STEPS] < -one_x) c_cl = -TRIG_ONE;
    else                          c_cl = TW'(x_r[STEPS]);
    if (y_r[STEPS] > one_x)       s_cl = TRIG_ONE;
    else if (y_r[STEPS] < -one_x) s_cl = -TRIG_ONE;
    else                          s_cl = TW'(y_r[STEPS]);
    unique case (q_r[STEPS])
      2'd0: begin trig_nxt.cos = c_cl;  trig_nxt.sin = s_cl;  end
      2'd1: begin trig_nxt.cos = -s_cl; trig_nxt.sin = c_cl;  end
      2'd2: begin trig_nxt.cos = -c_cl; trig_nxt.sin = -s_cl; end
      default: begin trig_nxt.cos = s_cl; trig_nxt.sin = -c_cl; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) trig_r <= trig_nxt;
  end

  assign trig = trig_r;

endmodule

[rtl/euler_angles_to_rotation_matrix.sv]
// Pipeline from input transfer to result: 32 CORDIC stages, then 5 matrix stages.
// One item per cycle while the output is not stalled; the whole pipeline advances together.
// The pipeline holds while a result waits and the output is not ready.
// Reset (synchronous, active low) clears the valid bits only; no state kept.
// ----------------------------------------------------------------------------
// euler_angles_to_rotation_matrix
// Heading/pitch/bank binary angles to a 3x3 rotation matrix in signed Q1.14.
// ----------------------------------------------------------------------------
module euler_angles_to_rotation_matrix
  import eatrm_pkg::*;
#(
  parameter int unsigned ANGLE_BITS = 16,
  parameter int unsigned FRAC_BITS  = 14
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [47:0]  in_tdata,   // heading_angle, pitch_angle, bank_angle
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [143:0] out_tdata   // row1_col1 .. row3_col3, 16 bits each
);

  localparam int unsigned CLAT = STEPS + 2;
  localparam int unsigned LAT  = CLAT + 5;
  localparam int unsigned RSH  = 60 - FRAC_BITS;

  logic en;
  logic [LAT-1:0] vld_r;

  assign out_tvalid = vld_r[LAT-1];
  assign en         = out_tready || !out_tvalid;
  assign in_tready  = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  // angle extended to a 32-bit turn; bits above ANGLE_BITS fall off the top
  logic [31:0] turn_h, turn_p, turn_b;
  assign turn_h = 32'(in_tdata[15:0])  << (32 - ANGLE_BITS);
  assign turn_p = 32'(in_tdata[31:16]) << (32 - ANGLE_BITS);
  assign turn_b = 32'(in_tdata[47:32]) << (32 - ANGLE_BITS);

  trig_t th, tp, tb;

  eatrm_cordic u_head  (.clk(clk), .en(en), .turn(turn_h), .trig(th));
  eatrm_cordic u_pitch (.clk(clk), .en(en), .turn(turn_p), .trig(tp));
  eatrm_cordic u_bank  (.clk(clk), .en(en), .turn(turn_b), .trig(tb));

  // stage 1: products
  logic signed [63:0] p_spsb_r, p_spcb_r, chcb_r, chsb_r, shcb_r, sbsh_r;
  logic signed [63:0] shcp_r, sbcp_r, cbcp_r, chcp_r;
  logic signed [TW-1:0] sh1_r, ch1_r, sp1_r;
  // stage 2: rounded pitch-bank terms
  logic signed [TW-1:0] spsb_r, spcb_r, sh2_r, ch2_r, sp2_r;
  logic signed [63:0] chcb2_r, chsb2_r, shcb2_r, sbsh2_r;
  logic signed [63:0] shcp2_r, sbcp2_r, cbcp2_r, chcp2_r;
  // stage 3: triple products
  logic signed [63:0] ma_r, mb_r, mc_r, md_r;
  logic signed [63:0] chcb3_r, chsb3_r, shcb3_r, sbsh3_r;
  logic signed [63:0] shcp3_r, sbcp3_r, cbcp3_r, chcp3_r;
  logic signed [TW-1:0] sp3_r;
  // stage 4: Q60 sums, stage 5: output entries
  logic signed [63:0] e_r [9];
  logic [15:0]        o_r [9];

  localparam logic signed [63:0] HALF30 = 64'sd1 <<< 29;

  // round Q60 to Q(FRAC_BITS), ties upward, clamp to plus or minus one
  function automatic logic [15:0] finish(input logic signed [63:0] v);
    logic signed [63:0] r;
    logic signed [63:0] one;
    one = 64'sd1 <<< FRAC_BITS;
    r   = (v + (64'sd1 <<< (RSH - 1))) >>> RSH;
    if (r > one)       r = one;
    else if (r < -one) r = -one;
    return r[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      p_spsb_r <= tp.sin * tb.sin;
      p_spcb_r <= tp.sin * tb.cos;
      chcb_r   <= th.cos * tb.cos;
      chsb_r   <= th.cos * tb.sin;
      shcb_r   <= th.sin * tb.cos;
      sbsh_r   <= tb.sin * th.sin;
      shcp_r   <= th.sin * tp.cos;
      sbcp_r   <= tb.sin * tp.cos;
      cbcp_r   <= tb.cos * tp.cos;
      chcp_r   <= th.cos * tp.cos;
      sh1_r    <= th.sin;
      ch1_r    <= th.cos;
      sp1_r    <= tp.sin;

      spsb_r  <= TW'((p_spsb_r + HALF30) >>> 30);
      spcb_r  <= TW'((p_spcb_r + HALF30) >>> 30);
      sh2_r   <= sh1_r;
      ch2_r   <= ch1_r;
      sp2_r   <= sp1_r;
      chcb2_r <= chcb_r;
      chsb2_r <= chsb_r;
      shcb2_r <= shcb_r;
      sbsh2_r <= sbsh_r;
      shcp2_r <= shcp_r;
      sbcp2_r <= sbcp_r;
      cbcp2_r <= cbcp_r;
      chcp2_r <= chcp_r;

      ma_r    <= sh2_r * spsb_r;
      mb_r    <= sh2_r * spcb_r;
      mc_r    <= ch2_r * spsb_r;
      md_r    <= ch2_r * spcb_r;
      chcb3_r <= chcb2_r;
      chsb3_r <= chsb2_r;
      shcb3_r <= shcb2_r;
      sbsh3_r <= sbsh2_r;
      shcp3_r <= shcp2_r;
      sbcp3_r <= sbcp2_r;
      cbcp3_r <= cbcp2_r;
      chcp3_r <= chcp2_r;
      sp3_r   <= sp2_r;

      e_r[0] <= chcb3_r + ma_r;
      e_r[1] <= mb_r - chsb3_r;
      e_r[2] <= shcp3_r;
      e_r[3] <= sbcp3_r;
      e_r[4] <= cbcp3_r;
      e_r[5] <= -(64'(sp3_r) <<< 30);
      e_r[6] <= mc_r - shcb3_r;
      e_r[7] <= sbsh3_r + md_r;
      e_r[8] <= chcp3_r;

      for (int k = 0; k < 9; k++) o_r[k] <= finish(e_r[k]);
    end
  end

  for (genvar k = 0; k < 9; k++) begin : g_out
    assign out_tdata[16*k +: 16] = o_r[k];
  end

  // ---- assertions ----
  a_rst_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("valid not cleared by reset");

  a_m23_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && FRAC_BITS <= 14) |->
      ($signed(out_tdata[95:80]) <= $signed(16'(1 << FRAC_BITS)) &&
       $signed(out_tdata[95:80]) >= -$signed(16'(1 << FRAC_BITS))))
    else $error("row2_col3 out of range");

  a_m11_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && FRAC_BITS <= 14) |->
      ($signed(out_tdata[15:0]) <= $signed(16'(1 << FRAC_BITS)) &&
       $signed(out_tdata[15:0]) >= -$signed(16'(1 << FRAC_BITS))))
    else $error("row1_col1 out of range");

  a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(vld_r))
    else $error("pipeline moved during stall");

endmodule
